@@ src/i2ctfb_pkg.sv @@
// ----------------------------------------------------------------------------
// i2ctfb_pkg
// Shared types and constants for the i2c target frame buffer.
// ----------------------------------------------------------------------------
package i2ctfb_pkg;

  localparam int FRAME_DEPTH_DEF = 7;

  // operation codes of one bus event
  typedef enum logic [2:0] {
    OP_SEND    = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_RX      = 3'd3,
    OP_TXREQ   = 3'd4,
    OP_RELEASE = 3'd5,
    OP_READ    = 3'd6
  } op_e;

  // frame kinds
  localparam logic [2:0] KIND_STATUS = 3'd2;
  localparam logic [2:0] KIND_MAX    = 3'd5;

  // receive phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_RECV    = 3'b010,
    PH_WAITING = 3'b100
  } phase_t;

  // receive phase as seen on the result channel
  localparam logic [1:0] RXS_IDLE    = 2'd0;
  localparam logic [1:0] RXS_RECV    = 2'd1;
  localparam logic [1:0] RXS_WAITING = 2'd2;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] frame_kind;
    logic [7:0] command;
    logic [7:0] status;
    logic [7:0] data1;
    logic [7:0] data2;
    logic [7:0] data3;
    logic       is_transmitter;
    logic [7:0] rx_byte;
    logic [2:0] read_index;
  } ev_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } tx_res_t;

  typedef struct packed {
    logic [1:0] state;
    logic [2:0] count;
    logic [7:0] data;
    logic       empty;
  } rx_res_t;

endpackage

@@ src/i2ctfb_tx.sv @@
// ----------------------------------------------------------------------------
// i2ctfb_tx
// Reply frame builder and transmit byte sequencer.
// ----------------------------------------------------------------------------
module i2ctfb_tx #(
  parameter int FRAME_DEPTH = i2ctfb_pkg::FRAME_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  i2ctfb_pkg::ev_t     ev,
  input  logic                rx_empty,
  output i2ctfb_pkg::tx_res_t res
);
  import i2ctfb_pkg::*;

  localparam int IDX_W = $clog2(FRAME_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_DEPTH - 1);

  logic [7:0]       frame_r [FRAME_DEPTH];
  logic             active_r, active_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic             kind_ok;
  logic             build;
  logic [1:0]       ndata;
  logic [7:0]       third;
  logic [7:0]       sum;
  logic [7:0]       dbyte [3];
  logic             wr_en  [FRAME_DEPTH];
  logic [7:0]       wr_dat [FRAME_DEPTH];

  assign kind_ok = (ev.frame_kind >= KIND_STATUS) && (ev.frame_kind <= KIND_MAX);
  assign build   = fire && (ev.op == OP_SEND) && kind_ok;
  assign ndata   = 2'(ev.frame_kind - KIND_STATUS);
  assign third   = (ev.frame_kind == KIND_STATUS) ? ev.status : 8'd0;
  assign dbyte[0] = ev.data1;
  assign dbyte[1] = ev.data2;
  assign dbyte[2] = ev.data3;

  always_comb begin
    sum = 8'(ev.frame_kind) ^ ev.command ^ third;
    for (int j = 0; j < 3; j++) begin
      if (j < int'(ndata)) sum = sum ^ dbyte[j];
    end
  end

  // entry writes for a new frame: header, data bytes, checksum
  always_comb begin
    for (int i = 0; i < FRAME_DEPTH; i++) begin
      wr_en[i]  = 1'b0;
      wr_dat[i] = 8'd0;
    end
    if (build) begin
      wr_en[0]  = 1'b1;
      wr_dat[0] = 8'(ev.frame_kind);
      wr_en[1]  = 1'b1;
      wr_dat[1] = ev.command;
      wr_en[2]  = 1'b1;
      wr_dat[2] = third;
      for (int j = 0; j < 3; j++) begin
        if (j < int'(ndata)) begin
          wr_en[3 + j]  = 1'b1;
          wr_dat[3 + j] = dbyte[j];
        end
      end
      wr_en[IDX_W'(3) + IDX_W'(ndata)]  = 1'b1;
      wr_dat[IDX_W'(3) + IDX_W'(ndata)] = sum;
    end
  end

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    res.valid  = 1'b0;
    res.data   = 8'd0;
    case (ev.op)
      OP_SEND: begin
        if (kind_ok) begin
          active_nxt = 1'b1;
          idx_nxt    = IDX_W'(1);
          res.valid  = 1'b1;
          res.data   = 8'(ev.frame_kind);
        end
      end
      OP_STOP: begin
        active_nxt = 1'b0;
      end
      OP_TXREQ: begin
        if (active_r) begin
          res.valid = 1'b1;
          res.data  = frame_r[idx_r];
          idx_nxt   = (idx_r == IDX_LAST) ? idx_r : idx_r + IDX_W'(1);
        end else if (rx_empty) begin
          // no active frame and receive index at zero: answer with a zero byte
          res.valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else if (fire) begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FRAME_DEPTH; i++) begin
      if (!rst_n) begin
        frame_r[i] <= 8'd0;
      end else if (wr_en[i]) begin
        frame_r[i] <= wr_dat[i];
      end
    end
  end

endmodule

@@ src/i2ctfb_rx.sv @@
// ----------------------------------------------------------------------------
// i2ctfb_rx
// Receive byte store, receive index and receive phase tracking.
// ----------------------------------------------------------------------------
module i2ctfb_rx #(
  parameter int FRAME_DEPTH = i2ctfb_pkg::FRAME_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  i2ctfb_pkg::ev_t     ev,
  output i2ctfb_pkg::rx_res_t res
);
  import i2ctfb_pkg::*;

  localparam int IDX_W = $clog2(FRAME_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_DEPTH - 1);

  logic [7:0]       store_r [FRAME_DEPTH];
  logic [IDX_W-1:0] idx_r, idx_nxt;
  phase_t           phase_r, phase_nxt;
  logic             wr_en;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_ok;
  logic [7:0]       rd_data;
  logic [1:0]       state_o;

  assign rd_idx = IDX_W'(ev.read_index);
  assign rd_ok  = int'(ev.read_index) < FRAME_DEPTH;
  assign wr_en  = fire && (ev.op == OP_RX);

  always_comb begin
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    rd_data   = 8'd0;
    case (ev.op)
      OP_START: begin
        // a start addressed for reading from us leaves the receive side alone
        if (!ev.is_transmitter) begin
          idx_nxt   = '0;
          phase_nxt = PH_RECV;
        end
      end
      OP_STOP: begin
        if (phase_r == PH_RECV) phase_nxt = PH_WAITING;
      end
      OP_RX: begin
        idx_nxt = (idx_r == IDX_LAST) ? idx_r : idx_r + IDX_W'(1);
      end
      OP_RELEASE: begin
        if (phase_r == PH_WAITING) phase_nxt = PH_IDLE;
      end
      OP_READ: begin
        if (rd_ok) rd_data = store_r[rd_idx];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (phase_nxt)
      PH_IDLE:    state_o = RXS_IDLE;
      PH_RECV:    state_o = RXS_RECV;
      PH_WAITING: state_o = RXS_WAITING;
      default:    state_o = RXS_IDLE;
    endcase
  end

  assign res = {state_o, idx_nxt[2:0], rd_data, (idx_r == '0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      phase_r <= PH_IDLE;
    end else if (fire) begin
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FRAME_DEPTH; i++) begin
      if (!rst_n) begin
        store_r[i] <= 8'd0;
      end else if (wr_en && (idx_r == IDX_W'(i))) begin
        store_r[i] <= ev.rx_byte;
      end
    end
  end

endmodule

@@ src/i2c_target_frame_buffer.sv @@
// ----------------------------------------------------------------------------
// i2c_target_frame_buffer
// Message side of an i2c target: reply frame transmit and receive buffering.
// ----------------------------------------------------------------------------
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------
//   in       | in_valid/in_ready   | operation, frame fields, rx_byte, index
//   out      | out_valid/out_ready | tx_valid, tx_byte, rx_state/count/data
//
// One result per transaction. An event sits in the input register, is
// applied to the buffers and lands in the output register; one event per
// cycle sustained while the output is not stalled.
// Synchronous active-low reset clears all buffers and counters.
// A stalled output holds the input register; the input side takes a new
// transaction whenever the input register is empty or moving on.
// ----------------------------------------------------------------------------
module i2c_target_frame_buffer #(
  parameter int FRAME_DEPTH = i2ctfb_pkg::FRAME_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_operation,
  input  logic [2:0] in_frame_kind,
  input  logic [7:0] in_command,
  input  logic [7:0] in_status,
  input  logic [7:0] in_data1,
  input  logic [7:0] in_data2,
  input  logic [7:0] in_data3,
  input  logic       in_is_transmitter,
  input  logic [7:0] in_rx_byte,
  input  logic [2:0] in_read_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic [1:0] out_rx_state,
  output logic [2:0] out_rx_count,
  output logic [7:0] out_rx_data
);
  import i2ctfb_pkg::*;

  logic    s1_valid_r;
  ev_t     s1_ev_r;
  logic    out_valid_r;
  tx_res_t tx_out_r;
  rx_res_t rx_out_r;
  logic    adv;
  logic    fire;
  tx_res_t tx_res;
  rx_res_t rx_res;

  assign adv      = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_ev_r.op             <= in_operation;
      s1_ev_r.frame_kind     <= in_frame_kind;
      s1_ev_r.command        <= in_command;
      s1_ev_r.status         <= in_status;
      s1_ev_r.data1          <= in_data1;
      s1_ev_r.data2          <= in_data2;
      s1_ev_r.data3          <= in_data3;
      s1_ev_r.is_transmitter <= in_is_transmitter;
      s1_ev_r.rx_byte        <= in_rx_byte;
      s1_ev_r.read_index     <= in_read_index;
    end
    if (fire) begin
      tx_out_r <= tx_res;
      rx_out_r <= rx_res;
    end
  end

  i2ctfb_rx #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_rx (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .ev    (s1_ev_r),
    .res   (rx_res)
  );

  i2ctfb_tx #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_tx (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .ev       (s1_ev_r),
    .rx_empty (rx_res.empty),
    .res      (tx_res)
  );

  assign out_valid    = out_valid_r;
  assign out_tx_valid = tx_out_r.valid;
  assign out_tx_byte  = tx_out_r.data;
  assign out_rx_state = rx_out_r.state;
  assign out_rx_count = rx_out_r.count;
  assign out_rx_data  = rx_out_r.data;

endmodule
